/* hw/rtl/bqlpf_pkg.sv */
`default_nettype none

package bqlpf_pkg;

    // Fixed internal widths: the delay states are 32-bit words. The accumulator
    // is a 64-bit word that saturates at +/-(2^63-1).
    localparam int WORD_W    = 32;
    localparam int ACC_W     = 64;
    localparam int SUM_W     = ACC_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [SUM_W-1:0] SUM_POS_LIM = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SUM_NEG_LIM = -SUM_POS_LIM;
    localparam logic signed [SUM_W-1:0] WORD_POS_LIM = SUM_W'({1'b0, {(WORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] WORD_NEG_LIM = -WORD_POS_LIM - SUM_W'(1);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0 = 3'd0,
        REG_COEF_B1 = 3'd1,
        REG_COEF_B2 = 3'd2,
        REG_COEF_A1 = 3'd3,
        REG_COEF_A2 = 3'd4
    } cfg_reg_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_B0_IN = 3'd0,   // b0 * incoming sample
        MUL_B1_X  = 3'd1,
        MUL_A1_Y  = 3'd2,
        MUL_B2_X  = 3'd3,
        MUL_A2_Y  = 3'd4
    } mul_sel_t;

    // Accumulator operations, all saturating
    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_PROD_D1   = 3'd1,   // acc = prod + delay_one
        ACC_LOAD_PROD = 3'd2,   // acc = prod
        ACC_SUB_PROD  = 3'd3,   // acc = acc - prod
        ACC_ADD_D2    = 3'd4    // acc = acc + delay_two
    } acc_op_t;

    // Where the rounded accumulator goes
    typedef enum logic [1:0] {
        RND_NONE = 2'd0,
        RND_YF   = 2'd1,
        RND_D1   = 2'd2,
        RND_D2   = 2'd3
    } rnd_dest_t;

    typedef struct packed {
        logic      capture;   // latch input sample, clear clip flag
        logic      mul_en;
        mul_sel_t  mul_sel;
        acc_op_t   acc_op;
        rnd_dest_t rnd_dest;
        logic      yo_en;     // round internal y to output sample
        logic      out_load;  // load output register
    } bqlpf_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/bqlpf_ctrl.sv */
`default_nettype none

module bqlpf_ctrl
    import bqlpf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output bqlpf_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_Y0   = 9'b000000010,
        ST_RY   = 9'b000000100,
        ST_MA1  = 9'b000001000,
        ST_SA1  = 9'b000010000,
        ST_AD2  = 9'b000100000,
        ST_RN1  = 9'b001000000,
        ST_SA2  = 9'b010000000,
        ST_RN2  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_B0_IN;
        cmd.acc_op   = ACC_HOLD;
        cmd.rnd_dest = RND_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_B0_IN;
                    state_next  = ST_Y0;
                end
            end
            ST_Y0: begin
                cmd.acc_op  = ACC_PROD_D1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B1_X;
                state_next  = ST_RY;
            end
            ST_RY: begin
                cmd.rnd_dest = RND_YF;
                cmd.acc_op   = ACC_LOAD_PROD;
                state_next   = ST_MA1;
            end
            ST_MA1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A1_Y;
                cmd.yo_en   = 1'b1;
                state_next  = ST_SA1;
            end
            ST_SA1: begin
                cmd.acc_op  = ACC_SUB_PROD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B2_X;
                state_next  = ST_AD2;
            end
            ST_AD2: begin
                cmd.acc_op = ACC_ADD_D2;
                state_next = ST_RN1;
            end
            ST_RN1: begin
                cmd.rnd_dest = RND_D1;
                cmd.acc_op   = ACC_LOAD_PROD;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_A2_Y;
                state_next   = ST_SA2;
            end
            ST_SA2: begin
                cmd.acc_op = ACC_SUB_PROD;
                state_next = ST_RN2;
            end
            ST_RN2: begin
                // wait here until the output slot is free
                if (out_free) begin
                    cmd.rnd_dest = RND_D2;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bqlpf_datapath.sv */
`default_nettype none

module bqlpf_datapath
    import bqlpf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_WIDTH  = 20
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire bqlpf_cmd_t                     cmd,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [COEFF_WIDTH-1:0]         cfg_wr_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    output logic                                clipped
);

    localparam int STATE_FRAC = WORD_W - SAMPLE_WIDTH;
    localparam int COEF_FRAC  = COEFF_WIDTH - 2;
    localparam int PROD_W     = COEFF_WIDTH + WORD_W;
    localparam int YO_W       = WORD_W + 1;
    localparam int YO_HALF_SH = (STATE_FRAC > 0) ? STATE_FRAC - 1 : 0;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [YO_W-1:0]  YO_HALF  =
        (STATE_FRAC > 0) ? (YO_W'(1) <<< YO_HALF_SH) : YO_W'(0);
    localparam logic signed [YO_W-1:0]  SMAX = (YO_W'(1) <<< (SAMPLE_WIDTH - 1)) - YO_W'(1);
    localparam logic signed [YO_W-1:0]  SMIN = -(YO_W'(1) <<< (SAMPLE_WIDTH - 1));

    // configuration
    logic signed [COEFF_WIDTH-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEFF_WIDTH-1:0] coef_a1_reg, coef_a2_reg;

    // state and working registers
    logic signed [WORD_W-1:0]       delay_one_reg, delay_two_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [WORD_W-1:0]       yf_reg;
    logic signed [SAMPLE_WIDTH-1:0] yo_reg;
    logic signed [ACC_W-1:0]        prod_reg, acc_reg, acc_next;
    logic                           clip_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           clipped_reg;

    // multiplier
    logic signed [COEFF_WIDTH-1:0] mul_coef;
    logic signed [WORD_W-1:0]      mul_opnd;
    logic signed [PROD_W-1:0]      mul_full;
    logic signed [WORD_W-1:0]      xs_in, xs_reg;

    // accumulator
    logic signed [SUM_W-1:0] acc_base, acc_term, acc_sum;

    // rounding units
    logic signed [SUM_W-1:0] rnd_sum, rnd_sat, rnd_shift;
    logic signed [WORD_W-1:0] rnd_word;
    logic                     rnd_clip;
    logic signed [YO_W-1:0]   yo_sum, yo_shift;
    logic signed [SAMPLE_WIDTH-1:0] yo_word;
    logic                     yo_clip;

    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    // sample scaled to state units
    assign xs_in  = WORD_W'(sample_in)  <<< STATE_FRAC;
    assign xs_reg = WORD_W'(sample_reg) <<< STATE_FRAC;

    always_comb begin
        case (cmd.mul_sel)
            MUL_B0_IN: begin mul_coef = coef_b0_reg; mul_opnd = xs_in;  end
            MUL_B1_X:  begin mul_coef = coef_b1_reg; mul_opnd = xs_reg; end
            MUL_A1_Y:  begin mul_coef = coef_a1_reg; mul_opnd = yf_reg; end
            MUL_B2_X:  begin mul_coef = coef_b2_reg; mul_opnd = xs_reg; end
            MUL_A2_Y:  begin mul_coef = coef_a2_reg; mul_opnd = yf_reg; end
            default:   begin mul_coef = coef_b0_reg; mul_opnd = xs_reg; end
        endcase
    end

    assign mul_full = mul_coef * mul_opnd;

    // saturating accumulate, limits +/-(2^63-1)
    always_comb begin
        case (cmd.acc_op)
            ACC_PROD_D1: begin
                acc_base = SUM_W'(prod_reg);
                acc_term = SUM_W'(delay_one_reg) <<< COEF_FRAC;
            end
            ACC_LOAD_PROD: begin
                acc_base = '0;
                acc_term = SUM_W'(prod_reg);
            end
            ACC_SUB_PROD: begin
                acc_base = SUM_W'(acc_reg);
                acc_term = -SUM_W'(prod_reg);
            end
            ACC_ADD_D2: begin
                acc_base = SUM_W'(acc_reg);
                acc_term = SUM_W'(delay_two_reg) <<< COEF_FRAC;
            end
            default: begin
                acc_base = SUM_W'(acc_reg);
                acc_term = '0;
            end
        endcase
        acc_sum = acc_base + acc_term;
        if (acc_sum > SUM_POS_LIM) begin
            acc_next = ACC_W'(SUM_POS_LIM);
        end else if (acc_sum < SUM_NEG_LIM) begin
            acc_next = ACC_W'(SUM_NEG_LIM);
        end else begin
            acc_next = ACC_W'(acc_sum);
        end
    end

    // accumulator -> 32-bit word: add half, floor, saturate
    always_comb begin
        rnd_sum  = SUM_W'(acc_reg) + RND_HALF;
        rnd_sat  = (rnd_sum > SUM_POS_LIM) ? SUM_POS_LIM : rnd_sum;
        rnd_shift = rnd_sat >>> COEF_FRAC;
        rnd_clip = 1'b0;
        if (rnd_shift > WORD_POS_LIM) begin
            rnd_word = WORD_W'(WORD_POS_LIM);
            rnd_clip = 1'b1;
        end else if (rnd_shift < WORD_NEG_LIM) begin
            rnd_word = WORD_W'(WORD_NEG_LIM);
            rnd_clip = 1'b1;
        end else begin
            rnd_word = WORD_W'(rnd_shift);
        end
    end

    // internal y -> output sample
    always_comb begin
        yo_sum   = YO_W'(yf_reg) + YO_HALF;
        yo_shift = yo_sum >>> STATE_FRAC;
        yo_clip  = 1'b0;
        if (yo_shift > SMAX) begin
            yo_word = SAMPLE_WIDTH'(SMAX);
            yo_clip = 1'b1;
        end else if (yo_shift < SMIN) begin
            yo_word = SAMPLE_WIDTH'(SMIN);
            yo_clip = 1'b1;
        end else begin
            yo_word = SAMPLE_WIDTH'(yo_shift);
        end
    end

    // configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg   <= '0;
            coef_b1_reg   <= '0;
            coef_b2_reg   <= '0;
            coef_a1_reg   <= '0;
            coef_a2_reg   <= '0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_COEF_B0: coef_b0_reg <= cfg_wr_data;
                    REG_COEF_B1: coef_b1_reg <= cfg_wr_data;
                    REG_COEF_B2: coef_b2_reg <= cfg_wr_data;
                    REG_COEF_A1: coef_a1_reg <= cfg_wr_data;
                    REG_COEF_A2: coef_a2_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.rnd_dest == RND_D1) begin
                delay_one_reg <= rnd_word;
            end
            if (cmd.rnd_dest == RND_D2) begin
                delay_two_reg <= rnd_word;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= sample_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= ACC_W'(mul_full);
        end
        acc_reg <= acc_next;
        if (cmd.rnd_dest == RND_YF) begin
            yf_reg <= rnd_word;
        end
        if (cmd.yo_en) begin
            yo_reg <= yo_word;
        end
        if (cmd.capture) begin
            clip_reg <= 1'b0;
        end else if (((cmd.rnd_dest != RND_NONE) && rnd_clip) || (cmd.yo_en && yo_clip)) begin
            clip_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            sample_out_reg <= yo_reg;
            clipped_reg    <= clip_reg | rnd_clip;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/biquad_lowpass_filter_unit.sv */
// Biquad IIR filter, transposed direct form II, fixed point.
// m_tvalid rises once an accepted item has run through the sequence and the output slot is free.
// A new item is taken only after the last one is done; the single shared multiplier and the
//   64-bit saturating accumulator step through five products and three roundings per item.
// Reset (aresetn low, synchronous): coefficients, both delay states and the output
//   valid are cleared; the controller returns to idle.
`default_nettype none

module biquad_lowpass_filter_unit
    import bqlpf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_WIDTH  = 20
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input item stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample_in
    // result item stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          m_tdata,   // sample_out
    output logic                                       m_tuser,   // clipped
    // coefficient write port: 0 b0, 1 b1, 2 b2, 3 a1, 4 a2 (signed Q2.(COEFF_WIDTH-2))
    input  wire logic                                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]                  cfg_index,
    input  wire logic [COEFF_WIDTH-1:0]                cfg_wr_data
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    bqlpf_cmd_t                     cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    // upper pad bits of s_tdata are ignored, m_tdata pads with zeros
    assign sample_in = s_tdata[SAMPLE_WIDTH-1:0];
    assign m_tdata   = TDATA_W'($unsigned(sample_out));
    assign m_tuser   = clipped;

    // Sequencer: one state per accumulator / multiplier step.
    //   accept : prod = b0*x
    //   Y0     : acc = prod + d1        prod = b1*x
    //   RY     : yf = rnd(acc)          acc = prod
    //   MA1    : prod = a1*yf           yo = rnd(yf)
    //   SA1    : acc -= prod            prod = b2*x
    //   AD2    : acc += d2
    //   RN1    : d1 = rnd(acc)          acc = prod, prod = a2*yf
    //   SA2    : acc -= prod
    //   RN2    : d2 = rnd(acc), load output (waits for a free output slot)
    bqlpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Coefficients, delay states, shared multiplier, accumulator and rounding.
    bqlpf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sample_in   (sample_in),
        .sample_out  (sample_out),
        .clipped     (clipped)
    );

endmodule

`default_nettype wire

/* hw/rtl/bqlpf_checker.sv */
`default_nettype none

module bqlpf_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic                              m_tuser
);

    logic s_accept;

    assign s_accept = s_tvalid && s_tready;

    // one item in flight: no new item right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("item accepted while previous item in progress");

    // still busy in the last step of the sequence
    a_busy_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> ##8 !s_tready)
        else $error("input ready before sequence finished");

    // a result is on the output once the sequence has run
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> ##9 m_tvalid)
        else $error("no result after sequence");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind biquad_lowpass_filter_unit bqlpf_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqlpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
